FILE: rtl/ndefhp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the NDEF record header parser.
// No dependencies; imported by every module of the block.
package ndefhp_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_RECORDS_DEF  = 8;
  localparam int unsigned MAX_TYPE_LEN_DEF = 8;

  // Bytes taken before the message counts as too long
  localparam logic [15:0] MAX_MESSAGE_BYTES = 16'd65535;

  // Result bus width: fields packed from bit 0, padded to whole bytes
  localparam int unsigned OUT_TDATA_W = 128;

  // Item codes on the input tuser
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Result kinds on the output tuser
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // Record header bit positions
  localparam int unsigned HDR_ME_BIT = 6;
  localparam int unsigned HDR_SR_BIT = 4;
  localparam int unsigned HDR_IL_BIT = 3;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TYPELEN = 3'd1,
    PH_PAYLEN  = 3'd2,
    PH_IDLEN   = 3'd3,
    PH_TYPE    = 3'd4,
    PH_ID      = 3'd5,
    PH_PAYLOAD = 3'd6
  } parse_phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  record_index;
    logic [7:0]  header_flags;
    logic [2:0]  tnf;
    logic [7:0]  type_length;
    logic [63:0] type_bytes;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [3:0]  records_parsed;
    logic        truncated;
    logic [1:0]  status;
  } res_t;

endpackage

FILE: rtl/ndefhp_in_stage.sv
`timescale 1ns / 1ps
// Input register of the NDEF record header parser: holds one accepted item.
// Depends on ndefhp_pkg.
module ndefhp_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ndefhp_pkg::in_item_t in_item,
  input  logic               advance,
  output logic               item_valid,
  output ndefhp_pkg::in_item_t item
);
  import ndefhp_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  // Take a new item whenever the held one is empty or moves on this cycle
  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: rtl/ndefhp_parser.sv
`timescale 1ns / 1ps
// Parse state and per-byte next-state logic of the NDEF record header parser.
// Depends on ndefhp_pkg.
module ndefhp_parser #(
  parameter int unsigned MAX_RECORDS  = ndefhp_pkg::MAX_RECORDS_DEF,
  parameter int unsigned MAX_TYPE_LEN = ndefhp_pkg::MAX_TYPE_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  ndefhp_pkg::in_item_t item,
  output logic                 res_valid,
  output ndefhp_pkg::res_t     res
);
  import ndefhp_pkg::*;

  localparam int unsigned RecCntW = $clog2(MAX_RECORDS + 1);

  typedef struct packed {
    parse_phase_t phase;
    logic [31:0]  left;
    logic         finish;
  } body_step_t;

  // Next non-empty body section after 'from', or finish the record
  function automatic body_step_t enter_body(parse_phase_t from, logic [7:0] tl,
                                            logic [7:0] idl, logic [31:0] plen);
    body_step_t s;
    s.phase  = PH_HEADER;
    s.left   = '0;
    s.finish = 1'b0;
    if (from < PH_TYPE && tl != 8'd0) begin
      s.phase = PH_TYPE;
      s.left  = {24'd0, tl};
    end else if (from < PH_ID && idl != 8'd0) begin
      s.phase = PH_ID;
      s.left  = {24'd0, idl};
    end else if (from < PH_PAYLOAD && plen != 32'd0) begin
      s.phase = PH_PAYLOAD;
      s.left  = plen;
    end else begin
      s.finish = 1'b1;
    end
    return s;
  endfunction

  parse_phase_t       phase_r, phase_nxt;
  logic [15:0]        pos_r, pos_nxt;
  logic [7:0]         hdr_r, hdr_nxt;
  logic [7:0]         tl_r, tl_nxt;
  logic [7:0]         idl_r, idl_nxt;
  logic [31:0]        plen_r, plen_nxt;
  logic [31:0]        left_r, left_nxt;
  logic [RecCntW-1:0] rec_r, rec_nxt;
  logic               trunc_r, trunc_nxt;
  logic               stop_r, stop_nxt;
  logic               long_r, long_nxt;
  logic [7:0]         store_r   [MAX_TYPE_LEN];
  logic [7:0]         store_nxt [MAX_TYPE_LEN];

  logic [31:0]        left_dec;
  logic [7:0]         type_idx;
  logic               type_wr;
  logic               emit;
  logic               summary;
  body_step_t         step;
  logic [63:0]        type_bytes;
  logic [RecCntW+3:0] rec_wide;

  assign left_dec = left_r - 32'd1;
  assign type_idx = tl_r - left_r[7:0];
  assign rec_wide = (RecCntW + 4)'(rec_r);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    tl_nxt    = tl_r;
    idl_nxt   = idl_r;
    plen_nxt  = plen_r;
    left_nxt  = left_r;
    rec_nxt   = rec_r;
    trunc_nxt = trunc_r;
    stop_nxt  = stop_r;
    long_nxt  = long_r;
    type_wr   = 1'b0;
    emit      = 1'b0;
    summary   = 1'b0;
    step      = '{phase: PH_HEADER, left: '0, finish: 1'b0};

    if (item.op == OP_END) begin
      summary   = 1'b1;
      phase_nxt = PH_HEADER;
      pos_nxt   = '0;
      hdr_nxt   = '0;
      tl_nxt    = '0;
      idl_nxt   = '0;
      plen_nxt  = '0;
      left_nxt  = '0;
      rec_nxt   = '0;
      trunc_nxt = 1'b0;
      stop_nxt  = 1'b0;
      long_nxt  = 1'b0;
    end else if (long_r) begin
      // drop every byte once the message ran too long
    end else if (pos_r >= MAX_MESSAGE_BYTES) begin
      long_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + 16'd1;
      if (!stop_r) begin
        case (phase_r)
          PH_HEADER: begin
            if (rec_r >= RecCntW'(MAX_RECORDS)) begin
              trunc_nxt = 1'b1;
              stop_nxt  = 1'b1;
            end else begin
              hdr_nxt   = item.data_byte;
              tl_nxt    = '0;
              idl_nxt   = '0;
              plen_nxt  = '0;
              phase_nxt = PH_TYPELEN;
            end
          end
          PH_TYPELEN: begin
            tl_nxt    = item.data_byte;
            phase_nxt = PH_PAYLEN;
            left_nxt  = hdr_r[HDR_SR_BIT] ? 32'd1 : 32'd4;
          end
          PH_PAYLEN: begin
            plen_nxt = {plen_r[23:0], item.data_byte};
            left_nxt = left_dec;
            if (left_dec == 32'd0) begin
              if (hdr_r[HDR_IL_BIT]) begin
                phase_nxt = PH_IDLEN;
              end else begin
                step = enter_body(PH_IDLEN, tl_r, idl_r, plen_nxt);
              end
            end
          end
          PH_IDLEN: begin
            idl_nxt = item.data_byte;
            step    = enter_body(PH_IDLEN, tl_r, idl_nxt, plen_r);
          end
          PH_TYPE: begin
            type_wr  = 1'b1;
            left_nxt = left_dec;
            if (left_dec == 32'd0) begin
              step = enter_body(PH_TYPE, tl_r, idl_r, plen_r);
            end
          end
          PH_ID: begin
            left_nxt = left_dec;
            if (left_dec == 32'd0) begin
              step = enter_body(PH_ID, tl_r, idl_r, plen_r);
            end
          end
          PH_PAYLOAD: begin
            left_nxt = left_dec;
            if (left_dec == 32'd0) begin
              step.finish = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_HEADER;
          end
        endcase

        // A section change or a finished record overrides the phase
        if (step.finish) begin
          emit      = 1'b1;
          rec_nxt   = rec_r + RecCntW'(1);
          phase_nxt = PH_HEADER;
          if (hdr_r[HDR_ME_BIT]) begin
            stop_nxt = 1'b1;
          end
        end else if (step.phase != PH_HEADER) begin
          phase_nxt = step.phase;
          left_nxt  = step.left;
        end
      end
    end
  end

  // Type byte store with this cycle's write folded in
  always_comb begin
    for (int i = 0; i < MAX_TYPE_LEN; i++) begin
      store_nxt[i] = store_r[i];
      if (type_wr && type_idx == 8'(i)) begin
        store_nxt[i] = item.data_byte;
      end
    end
  end

  // Only bytes below the declared type length belong to this record
  always_comb begin
    type_bytes = '0;
    for (int i = 0; i < MAX_TYPE_LEN; i++) begin
      if (8'(i) < tl_r) begin
        type_bytes[8*i +: 8] = store_nxt[i];
      end
    end
  end

  always_comb begin
    res       = '0;
    res_valid = emit || summary;
    if (summary) begin
      res.kind           = KIND_SUMMARY;
      res.records_parsed = rec_wide[3:0];
      res.truncated      = trunc_r;
      if (long_r) begin
        res.status = ST_TOO_LONG;
      end else if (pos_r == 16'd0) begin
        res.status = ST_EMPTY;
      end else begin
        res.status = ST_OK;
      end
    end else begin
      res.kind           = KIND_RECORD;
      res.record_index   = rec_wide[2:0];
      res.header_flags   = hdr_r;
      res.tnf            = hdr_r[2:0];
      res.type_length    = tl_r;
      res.type_bytes     = type_bytes;
      res.payload_offset = pos_nxt - plen_nxt[15:0];
      res.payload_length = plen_nxt[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      hdr_r   <= '0;
      tl_r    <= '0;
      idl_r   <= '0;
      plen_r  <= '0;
      left_r  <= '0;
      rec_r   <= '0;
      trunc_r <= 1'b0;
      stop_r  <= 1'b0;
      long_r  <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hdr_r   <= hdr_nxt;
      tl_r    <= tl_nxt;
      idl_r   <= idl_nxt;
      plen_r  <= plen_nxt;
      left_r  <= left_nxt;
      rec_r   <= rec_nxt;
      trunc_r <= trunc_nxt;
      stop_r  <= stop_nxt;
      long_r  <= long_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < MAX_TYPE_LEN; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

endmodule

FILE: rtl/ndefhp_out_stage.sv
`timescale 1ns / 1ps
// Result register of the NDEF record header parser: holds one result item.
// Depends on ndefhp_pkg.
module ndefhp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             res_valid,
  input  ndefhp_pkg::res_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_ready,
  output ndefhp_pkg::res_t out_res
);
  import ndefhp_pkg::*;

  logic valid_r;
  res_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

FILE: rtl/ndef_record_header_parser.sv
`timescale 1ns / 1ps
// NDEF record header parser: streams message bytes in, record and summary items out.
// Depends on ndefhp_pkg, ndefhp_in_stage, ndefhp_parser and ndefhp_out_stage.
//
// Usage:
//   in_*  : one item per handshake. in_tuser = 0 carries a message byte in in_tdata,
//           in_tuser = 1 closes the message (in_tdata ignored).
//   out_* : out_tuser = 0 is a completed record, 1 is the end-of-message summary.
//   A record item leaves on the byte that completes the record; the end item always
//   yields one summary and returns the parser to its reset state for the next message.
// Order: an accepted item waits in the input register, passes through the parse logic
//   and any result is registered in the result register, which raises out_tvalid.
// Throughput: one item per cycle while the result register is free, set by the single
//   pass through the parse logic between the input register and the result register.
// Stall: while the receiver holds out_tready low and a result is waiting, one more
//   input item is taken into the input register; in_tready then drops until the
//   result drains.
// Reset: rst_n (synchronous, active low) empties both registers and clears the parse
//   state; the type byte store is not cleared and is read only after being written.
module ndef_record_header_parser #(
  parameter int unsigned MAX_RECORDS  = ndefhp_pkg::MAX_RECORDS_DEF,
  parameter int unsigned MAX_TYPE_LEN = ndefhp_pkg::MAX_TYPE_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,  // [7:0] data_byte
  input  logic                               in_tuser,  // [0] op
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] record_index, [10:3] header_flags, [13:11] tnf, [21:14] type_length,
  // [85:22] type_bytes, [101:86] payload_offset, [117:102] payload_length,
  // [121:118] records_parsed, [122] truncated, [124:123] status, [127:125] zero
  output logic [ndefhp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser  // [0] kind
);
  import ndefhp_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  logic     out_free;
  logic     res_valid;
  res_t     res;
  res_t     out_res;

  assign in_item = '{op: in_tuser, data_byte: in_tdata};

  // Move the held item through the parser when the result register can take it
  assign advance = item_valid && out_free;

  ndefhp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .advance   (advance),
    .item_valid(item_valid),
    .item      (item)
  );

  ndefhp_parser #(
    .MAX_RECORDS (MAX_RECORDS),
    .MAX_TYPE_LEN(MAX_TYPE_LEN)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .item     (item),
    .res_valid(res_valid),
    .res      (res)
  );

  ndefhp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .res_valid(res_valid),
    .res      (res),
    .out_free (out_free),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  // Pack result fields from bit 0 upward, pad to whole bytes
  assign out_tuser = out_res.kind;
  assign out_tdata = {3'b000,
                      out_res.status,
                      out_res.truncated,
                      out_res.records_parsed,
                      out_res.payload_length,
                      out_res.payload_offset,
                      out_res.type_bytes,
                      out_res.type_length,
                      out_res.tnf,
                      out_res.header_flags,
                      out_res.record_index};

endmodule
